// ----- rtl/lesf_pkg.sv -----
// Shared types, constants and helpers for the largest empty square finder.
// No dependencies; the result interface, the top level and the testbench refer to this package.
`default_nettype none

package lesf_pkg;

  // Largest map side that the scan supports, in rows and in columns.
  localparam int MAP_LIMIT = 1024;

  localparam int SIZE_W = 11;
  localparam int POS_W = 10;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 11;

  typedef logic [SIZE_W-1:0] size_t;
  typedef logic [POS_W-1:0] pos_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MAP_ROWS = 2'd0,
    REG_MAP_COLS = 2'd1
  } cfg_reg_t;

  // Clamps a requested map side to 1..limit and returns the index of the last
  // row or column.
  function automatic pos_t last_index(input size_t value, input size_t limit);
    size_t c;
    begin
      c = value;
      if (c == size_t'(0)) c = size_t'(1);
      if (c > limit) c = limit;
      return pos_t'(c - size_t'(1));
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/lesf_cell_if.sv -----
// Valid/ready channel that carries one map cell per word.
// Depends on nothing but the handshake convention of the block.
`default_nettype none

interface lesf_cell_if;
  logic valid;
  logic ready;
  logic cell_empty;

  modport source (output valid, output cell_empty, input ready);
  modport sink (input valid, input cell_empty, output ready);
endinterface

`default_nettype wire

// ----- rtl/lesf_result_if.sv -----
// Valid/ready channel that carries the largest square found in one map.
// Depends on lesf_pkg for the size and position types.
`default_nettype none

interface lesf_result_if;
  logic valid;
  logic ready;
  lesf_pkg::size_t square_size;
  lesf_pkg::pos_t top_row;
  lesf_pkg::pos_t left_col;

  modport source (output valid, output square_size, output top_row, output left_col,
                  input ready);
  modport sink (input valid, input square_size, input top_row, input left_col,
                output ready);
endinterface

`default_nettype wire

// ----- rtl/lesf_line_buf.sv -----
// Line buffer of square sizes: one write port and one registered read port.
// Stand-alone; used by the top level of the largest empty square finder.
`default_nettype none

module lesf_line_buf #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 11,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read of the address written in the same cycle returns the new data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/largest_empty_square_finder_unit.sv -----
// Top level of the largest empty square finder.
// Depends on lesf_pkg, lesf_cell_if, lesf_result_if and lesf_line_buf.
`default_nettype none

// The block takes the cells of a binary obstacle map, one word per cell, in
// reverse raster order: the last row first, and each row from right to left.
// It counts the cell position itself from map_rows and map_cols (register
// indexes 0 and 1, each clamped to 1..1024, map_cols also to MAX_COLS); a write
// to either register restarts the scan at the last row and column and clears
// the best square found so far, while a write to any other index is ignored.
// One cell is accepted in every cycle unless a waiting result holds off the
// final cell of a map. The size of the square whose top-left corner is the
// current cell is formed in the same cycle from the line buffer entry of the
// row below, which is read one cell ahead through the buffer's registered
// port, and from the right and lower-right sizes held in registers. The cell
// at row 0, column 0 loads the result word (size, top row, left column) into
// the output register as it is accepted, and the scan begins again for the
// next map. Input stays open while a result waits, except for the final cell
// of the next map, which waits until the result is taken. The line buffer needs
// no clearing pass: a scan uses only entries that it wrote on the row below.
module largest_empty_square_finder_unit #(
  parameter int MAX_COLS = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  lesf_cell_if.sink                              cells,
  lesf_result_if.source                          result,
  input  wire logic                              cfg_write,
  input  wire logic [lesf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [lesf_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int ADDR_W = $clog2(MAX_COLS);
  localparam int COL_LIMIT = (MAX_COLS < lesf_pkg::MAP_LIMIT) ? MAX_COLS
                                                               : lesf_pkg::MAP_LIMIT;

  // Scan geometry, kept as the index of the last row and column.
  lesf_pkg::pos_t map_rows_last;
  lesf_pkg::pos_t map_cols_last;

  // Position of the next cell to arrive.
  lesf_pkg::pos_t row_position;
  lesf_pkg::pos_t col_position;

  // Sizes of the right and lower-right neighbours of the next cell.
  lesf_pkg::size_t right_size;
  lesf_pkg::size_t lower_right_size;

  // Best square so far.
  lesf_pkg::size_t best_size;
  lesf_pkg::pos_t best_row;
  lesf_pkg::pos_t best_col;

  lesf_pkg::size_t best_size_next;
  lesf_pkg::pos_t best_row_next;
  lesf_pkg::pos_t best_col_next;

  logic accept;
  logic final_cell;
  logic row_end;
  logic at_border;
  logic cfg_hit;
  lesf_pkg::size_t below;
  lesf_pkg::size_t least;
  lesf_pkg::size_t cell_size;
  lesf_pkg::pos_t col_step;
  lesf_pkg::pos_t rows_last_cfg;
  lesf_pkg::pos_t cols_last_cfg;

  // The final cell of a map may enter only when the output register is empty or is being emptied.
  assign final_cell = (row_position == '0) && (col_position == '0);
  assign row_end    = (col_position == '0);
  assign cells.ready = !result.valid || result.ready || !final_cell;
  assign accept = cells.valid && cells.ready;

  assign cfg_hit = cfg_write &&
                   ((cfg_index == lesf_pkg::REG_MAP_ROWS) ||
                    (cfg_index == lesf_pkg::REG_MAP_COLS));
  assign rows_last_cfg = lesf_pkg::last_index(cfg_data,
                                              lesf_pkg::size_t'(lesf_pkg::MAP_LIMIT));
  assign cols_last_cfg = lesf_pkg::last_index(cfg_data, lesf_pkg::size_t'(COL_LIMIT));

  // Column of the cell after this one; the line buffer is read there now so
  // that its entry is ready when that cell arrives.
  assign col_step = row_end ? map_cols_last : (col_position - lesf_pkg::pos_t'(1));

  lesf_line_buf #(
    .DEPTH (MAX_COLS),
    .WIDTH (lesf_pkg::SIZE_W)
  ) u_line_buf (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (ADDR_W'(col_position)),
    .wr_data (cell_size),
    .rd_en   (accept),
    .rd_addr (ADDR_W'(col_step)),
    .rd_data (below)
  );

  // Square size for the current cell: cells on the last row or column can
  // only hold a unit square.
  always_comb begin
    at_border = (row_position == map_rows_last) || (col_position == map_cols_last);
    least = below;
    if (right_size < least) least = right_size;
    if (lower_right_size < least) least = lower_right_size;
    if (!cells.cell_empty) begin
      cell_size = '0;
    end else if (at_border) begin
      cell_size = lesf_pkg::size_t'(1);
    end else begin
      cell_size = least + lesf_pkg::size_t'(1);
    end
  end

  // A larger square takes over; an equal one moves the corner up or left.
  always_comb begin
    best_size_next = best_size;
    best_row_next  = best_row;
    best_col_next  = best_col;
    if (cells.cell_empty) begin
      if (cell_size > best_size) begin
        best_size_next = cell_size;
        best_row_next  = row_position;
        best_col_next  = col_position;
      end else if ((cell_size == best_size) &&
                   ((row_position < best_row) ||
                    ((row_position == best_row) && (col_position < best_col)))) begin
        best_row_next = row_position;
        best_col_next = col_position;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      map_rows_last    <= lesf_pkg::pos_t'(lesf_pkg::MAP_LIMIT - 1);
      map_cols_last    <= lesf_pkg::pos_t'(COL_LIMIT - 1);
      row_position     <= lesf_pkg::pos_t'(lesf_pkg::MAP_LIMIT - 1);
      col_position     <= lesf_pkg::pos_t'(COL_LIMIT - 1);
      right_size       <= '0;
      lower_right_size <= '0;
      best_size        <= '0;
      best_row         <= '0;
      best_col         <= '0;
    end else if (cfg_hit) begin
      // A register write restarts the scan with the new geometry.
      unique case (cfg_index)
        lesf_pkg::REG_MAP_ROWS: begin
          map_rows_last <= rows_last_cfg;
          row_position  <= rows_last_cfg;
          col_position  <= map_cols_last;
        end
        lesf_pkg::REG_MAP_COLS: begin
          map_cols_last <= cols_last_cfg;
          row_position  <= map_rows_last;
          col_position  <= cols_last_cfg;
        end
        default: begin
        end
      endcase
      right_size       <= '0;
      lower_right_size <= '0;
      best_size        <= '0;
      best_row         <= '0;
      best_col         <= '0;
    end else if (accept) begin
      if (final_cell) begin
        row_position     <= map_rows_last;
        col_position     <= map_cols_last;
        right_size       <= '0;
        lower_right_size <= '0;
        best_size        <= '0;
        best_row         <= '0;
        best_col         <= '0;
      end else if (row_end) begin
        row_position     <= row_position - lesf_pkg::pos_t'(1);
        col_position     <= map_cols_last;
        right_size       <= '0;
        lower_right_size <= '0;
        best_size        <= best_size_next;
        best_row         <= best_row_next;
        best_col         <= best_col_next;
      end else begin
        col_position     <= col_step;
        right_size       <= cell_size;
        lower_right_size <= below;
        best_size        <= best_size_next;
        best_row         <= best_row_next;
        best_col         <= best_col_next;
      end
    end
  end

  // Output register for the result word.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (accept && final_cell) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && final_cell) begin
      result.square_size <= best_size_next;
      result.top_row     <= best_row_next;
      result.left_col    <= best_col_next;
    end
  end

`ifndef SYNTH
  // A result appears only after the final cell of a map.
  a_result_after_final: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(accept && final_cell))
    else $error("result word without a final cell");

  // The final cell sends the scan back to the last row and column.
  a_restart_after_final: assert property (@(posedge clk) disable iff (rst)
    (accept && final_cell && !cfg_write) |=>
      ((row_position == map_rows_last) && (col_position == map_cols_last) &&
       (best_size == '0)))
    else $error("scan did not restart after the final cell");

  // An empty cell inside a map leaves a nonzero best square behind.
  a_best_nonzero: assert property (@(posedge clk) disable iff (rst)
    (accept && cells.cell_empty && !final_cell && !cfg_write) |=> (best_size != '0))
    else $error("empty cell not counted in best square");

  // Input is held off only by a waiting result.
  a_ready_only_stalled: assert property (@(posedge clk) disable iff (rst)
    !cells.ready |-> (result.valid && !result.ready && final_cell))
    else $error("input stalled without a waiting result");
`endif

endmodule

`default_nettype wire

// ----- verif/largest_empty_square_finder_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for largest_empty_square_finder_unit: streams obstacle maps
// word by word and checks every reported square against its own scan model.
// Depends on lesf_pkg, lesf_cell_if, lesf_result_if and the block's RTL.

module largest_empty_square_finder_unit_tb;
  import lesf_pkg::*;

  localparam int MAX_COLS = 1024;
  // Generous bound on the simulated run time of a correct run.
  localparam int CYCLE_LIMIT = 600000;
  // The result register is loaded as the final cell is accepted; the wait is slack beyond that.
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 200;

  // Indexes beyond the two registers; the block must ignore writes to them.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

  typedef struct {
    size_t sq_size;
    pos_t  sq_row;
    pos_t  sq_col;
  } square_t;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lesf_cell_if cell_ch ();
  lesf_result_if square_ch ();

  largest_empty_square_finder_unit #(
    .MAX_COLS(MAX_COLS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cells(cell_ch),
    .result(square_ch),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Scan model state. It mirrors what the block must hold: the two registers,
  // the line of sizes from the row below, the right and lower-right window, the
  // scan position and the best square found so far in the current map.
  size_t map_rows_reg;
  size_t map_cols_reg;
  size_t size_line [MAX_COLS];
  size_t right_sz;
  size_t diag_sz;
  pos_t scan_row;
  pos_t scan_col;
  size_t best_sz;
  pos_t best_row;
  pos_t best_col;

  // Squares that the block still owes, oldest first.
  square_t expected_squares[$];

  int error_count = 0;
  int cells_sent = 0;
  int squares_checked = 0;
  int reg_writes = 0;
  int cycle_count = 0;

  // Per-item idling of the sender and the receiver can be switched off so that
  // some stretches run at full rate.
  bit tx_idle;
  bit rx_idle;

  // The long receiver hold-off is timed by its own process below.
  event hold_go;
  bit holding = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d squares still owed", cycle_count,
               expected_squares.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Scan model
  // ---------------------------------------------------------------------------

  function automatic int rows_in_use();
    int r;
    r = int'(map_rows_reg);
    if (r < 1) r = 1;
    if (r > MAP_LIMIT) r = MAP_LIMIT;
    return r;
  endfunction

  function automatic int cols_in_use();
    int c;
    c = int'(map_cols_reg);
    if (c < 1) c = 1;
    if (c > MAP_LIMIT) c = MAP_LIMIT;
    if (c > MAX_COLS) c = MAX_COLS;
    return c;
  endfunction

  // A new map always starts at its last row and last column with nothing found.
  task automatic restart_scan();
    scan_row = pos_t'(rows_in_use() - 1);
    scan_col = pos_t'(cols_in_use() - 1);
    right_sz = '0;
    diag_sz = '0;
    best_sz = '0;
    best_row = '0;
    best_col = '0;
  endtask

  task automatic reset_model();
    map_rows_reg = size_t'(MAP_LIMIT);
    map_cols_reg = size_t'(MAP_LIMIT);
    foreach (size_line[i]) size_line[i] = '0;
    restart_scan();
  endtask

  task automatic apply_reg_write(input logic [CFG_INDEX_W-1:0] idx, input size_t data);
    if (idx == REG_MAP_ROWS) begin
      map_rows_reg = data;
      restart_scan();
    end else if (idx == REG_MAP_COLS) begin
      map_cols_reg = data;
      restart_scan();
    end
  endtask

  // Advances the scan by one cell and, after the cell at row 0, column 0,
  // queues the best square of the map.
  task automatic scan_cell(input bit empty);
    int rows;
    int cols;
    int row;
    int col;
    size_t below;
    size_t least;
    size_t sz;
    bit on_border;
    square_t sq;
    rows = rows_in_use();
    cols = cols_in_use();
    row = int'(scan_row);
    col = int'(scan_col);
    if (row >= rows) row = rows - 1;
    if (col >= cols) col = cols - 1;
    on_border = (row == rows - 1) || (col == cols - 1);
    below = size_line[col];
    least = below;
    if (right_sz < least) least = right_sz;
    if (diag_sz < least) least = diag_sz;
    if (!empty) sz = '0;
    else if (on_border) sz = size_t'(1);
    else sz = least + size_t'(1);
    size_line[col] = sz;
    diag_sz = below;
    right_sz = sz;
    // Ties go to the later cell, which lies higher or, on one row, further left.
    if (empty) begin
      if (sz > best_sz) begin
        best_sz = sz;
        best_row = pos_t'(row);
        best_col = pos_t'(col);
      end else if (sz == best_sz && (row < int'(best_row) ||
                   (row == int'(best_row) && col < int'(best_col)))) begin
        best_row = pos_t'(row);
        best_col = pos_t'(col);
      end
    end
    if (col > 0) begin
      scan_col = pos_t'(col - 1);
      scan_row = pos_t'(row);
    end else if (row > 0) begin
      scan_col = pos_t'(cols - 1);
      scan_row = pos_t'(row - 1);
      right_sz = '0;
      diag_sz = '0;
    end else begin
      sq.sq_size = best_sz;
      sq.sq_row = best_row;
      sq.sq_col = best_col;
      expected_squares.push_back(sq);
      restart_scan();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offers one cell and returns right after the edge that accepted it. Valid is
  // left high so that a following cell goes out with no bubble; anything that
  // stops sending lowers it first.
  task automatic send_cell(input bit empty);
    int gap;
    gap = tx_idle ? $urandom_range(0, 10) : 0;
    @(negedge clk);
    if (gap > 0) begin
      cell_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cell_ch.valid <= 1'b1;
    cell_ch.cell_empty <= empty;
    do @(posedge clk); while (!cell_ch.ready);
    scan_cell(empty);
    cells_sent++;
  endtask

  // Sends one whole map whose cells are empty with the given chance in percent.
  task automatic send_map(input int empty_pct);
    int total;
    total = rows_in_use() * cols_in_use();
    repeat (total) send_cell($urandom_range(0, 99) < empty_pct);
  endtask

  // Stops the sender and waits until every owed square has come back. With
  // settle set it also waits out the block's latency, since cells of a map
  // that was broken off may still be in flight.
  task automatic wait_all_squares(input bit settle);
    @(negedge clk);
    cell_ch.valid <= 1'b0;
    while (expected_squares.size() != 0) @(posedge clk);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes happen only while the block is idle; callers drain first.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input size_t data);
    @(negedge clk);
    cell_ch.valid <= 1'b0;
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    apply_reg_write(idx, data);
    reg_writes++;
  endtask

  task automatic set_map(input size_t rows, input size_t cols);
    wait_all_squares(1'b1);
    write_reg(REG_MAP_ROWS, rows);
    write_reg(REG_MAP_COLS, cols);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver and checker
  // ---------------------------------------------------------------------------

  task automatic report(input string msg);
    error_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_square();
    square_t want;
    if (expected_squares.size() == 0) begin
      report($sformatf("square word with none owed: size %0d row %0d col %0d",
                       square_ch.square_size, square_ch.top_row, square_ch.left_col));
      return;
    end
    want = expected_squares.pop_front();
    if (square_ch.square_size !== want.sq_size)
      report($sformatf("square_size got %0d expected %0d", square_ch.square_size,
                       want.sq_size));
    if (square_ch.top_row !== want.sq_row)
      report($sformatf("top_row got %0d expected %0d", square_ch.top_row, want.sq_row));
    if (square_ch.left_col !== want.sq_col)
      report($sformatf("left_col got %0d expected %0d", square_ch.left_col,
                       want.sq_col));
    squares_checked++;
  endtask

  // Samples at the rising edge, drives ready at the falling edge. After each
  // accepted word the receiver holds ready low for a randomly drawn stall when
  // idling is on; during a long hold-off ready stays low throughout.
  initial begin : square_sink
    int rx_wait;
    rx_wait = 0;
    square_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && square_ch.valid && square_ch.ready) begin
        check_square();
        rx_wait = rx_idle ? $urandom_range(0, 10) : 0;
      end
      @(negedge clk);
      if (holding) begin
        square_ch.ready <= 1'b0;
      end else if (rx_wait != 0) begin
        square_ch.ready <= 1'b0;
        rx_wait--;
      end else begin
        square_ch.ready <= 1'b1;
      end
    end
  end

  // Times the long hold-off in clock cycles; it is started from a test.
  initial begin : hold_timer
    forever begin
      @(hold_go);
      holding = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      holding = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // A zero written to either register clamps to a 1x1 map: an empty cell is a
  // square of one at the origin and an obstacle reports nothing found.
  task automatic test_single_cell();
    set_map(size_t'(0), size_t'(0));
    send_cell(1'b1);
    send_cell(1'b0);
    send_cell(1'b1);
  endtask

  // All obstacles, an all-empty square map, a taller map where the upper of
  // two equal squares must win, and a single row where the leftmost cell wins.
  task automatic test_directed_maps();
    set_map(size_t'(2), size_t'(2));
    repeat (4) send_cell(1'b0);
    set_map(size_t'(3), size_t'(3));
    repeat (9) send_cell(1'b1);
    set_map(size_t'(3), size_t'(2));
    repeat (6) send_cell(1'b1);
    set_map(size_t'(1), size_t'(3));
    repeat (3) send_cell(1'b1);
  endtask

  // Writes to the two unused indexes must leave the scan untouched.
  task automatic test_spare_index();
    set_map(size_t'(3), size_t'(4));
    write_reg(REG_SPARE_LO, size_t'(2047));
    write_reg(REG_SPARE_HI, size_t'(0));
    send_map(80);
    wait_all_squares(1'b1);
    write_reg(REG_SPARE_HI, size_t'(2047));
    write_reg(REG_SPARE_LO, size_t'(0));
    send_map(80);
  endtask

  // A map broken off partway is discarded by a register write, even one that
  // writes the value already held, and the next map starts clean.
  task automatic test_restart();
    set_map(size_t'(4), size_t'(5));
    repeat (7) send_cell(1'b1);
    wait_all_squares(1'b1);
    write_reg(REG_MAP_COLS, size_t'(5));
    send_map(70);
    repeat (11) send_cell(1'b1);
    wait_all_squares(1'b1);
    write_reg(REG_MAP_ROWS, size_t'(4));
    send_map(90);
  endtask

  // The receiver holds off for a long stretch while small maps keep coming,
  // so a result waits and the final cell of the next map is held at the input.
  // Then the sender pauses until every owed square has come.
  task automatic test_backpressure();
    set_map(size_t'(2), size_t'(2));
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_cell(1'b1);
    -> hold_go;
    repeat (15) send_cell($urandom_range(0, 1));
    wait_all_squares(1'b0);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // Random phases of a few maps with one shape each. Most maps are complete
  // with random content; now and then a phase ends in a map broken off, which
  // the next register write throws away.
  task automatic test_random();
    int start_cells;
    int rows;
    int cols;
    int pct;
    int partial;
    start_cells = cells_sent;
    while (cells_sent - start_cells < 250) begin
      rows = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      cols = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      // A one-sided map is sometimes set by writing zero, which clamps to one.
      set_map((rows == 1 && $urandom_range(0, 1)) ? size_t'(0) : size_t'(rows),
              (cols == 1 && $urandom_range(0, 1)) ? size_t'(0) : size_t'(cols));
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 3))
        0: pct = 50;
        1: pct = 75;
        2: pct = 92;
        default: pct = 100;
      endcase
      repeat ($urandom_range(1, 4)) send_map(pct);
      if (rows * cols > 1 && $urandom_range(0, 7) == 0) begin
        partial = $urandom_range(1, rows * cols - 1);
        repeat (partial) send_cell($urandom_range(0, 1));
      end
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // A 12x12 map, almost all empty, sent at full rate grows a large square.
  task automatic test_large_square();
    tx_idle = 1'b0;
    set_map(size_t'(12), size_t'(12));
    send_map(99);
    tx_idle = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin : main
    rst <= 1'b1;
    cell_ch.valid <= 1'b0;
    cell_ch.cell_empty <= 1'b0;
    cfg_write <= 1'b0;
    cfg_index <= REG_MAP_ROWS;
    cfg_data <= '0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    reset_model();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_single_cell();
    test_directed_maps();
    test_spare_index();
    test_restart();
    test_backpressure();
    test_random();
    test_large_square();

    wait_all_squares(1'b1);
    $display("Sent %0d cells over %0d register writes and checked %0d squares,",
             cells_sent, reg_writes, squares_checked);
    $display("including clamped sizes, broken-off maps and a long output stall.");
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", error_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/lesf_pkg.sv
rtl/lesf_cell_if.sv
rtl/lesf_result_if.sv
rtl/lesf_line_buf.sv
rtl/largest_empty_square_finder_unit.sv
verif/largest_empty_square_finder_unit_tb.sv
